@@ src/pcg_pkg.sv @@
// ----------------------------------------------------------------------------
// pcg_pkg: shared types, constants and microcode for the PCG32 noise source
// Holds the LCG multiplier halves, the XSH-RR output permutation, the control
// word layout and the read-only program that sequences the datapath.
// ----------------------------------------------------------------------------
package pcg_pkg;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  // 64-bit LCG multiplier, split into 32-bit halves for the shared multiplier.
  localparam logic [31:0] MUL_HI = 32'h5851_F42D;
  localparam logic [31:0] MUL_LO = 32'h4C95_7F2D;

  // Program entry points.
  localparam pc_t PC_IDLE   = pc_t'(0);
  localparam pc_t PC_RESEED = pc_t'(1);
  localparam pc_t PC_DRAW   = pc_t'(11);

  // Multiplier use: full low product, or one of the two cross terms.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_FULL,
    MUL_LO_HI,
    MUL_HI_LO
  } mul_sel_t;

  // State register operation.
  typedef enum logic [1:0] {
    ST_HOLD,
    ST_CLR,
    ST_SEED,
    ST_UPD
  } st_op_t;

  // Sequencing operation.
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT,
    SEQ_DONE
  } seq_op_t;

  // Datapath control, sent from the sequencer to the datapath.
  typedef struct packed {
    mul_sel_t mul_sel;
    st_op_t   st_op;
    logic     cap_rb;
    logic     cap_g;
  } dp_ctrl_t;

  typedef struct packed {
    seq_op_t  seq_op;
    pc_t      target;
    dp_ctrl_t dp;
  } ucode_t;

  function automatic ucode_t uword(seq_op_t s, pc_t t, mul_sel_t m, st_op_t o,
                                   logic crb, logic cg);
    ucode_t w;
    w.seq_op    = s;
    w.target    = t;
    w.dp.mul_sel = m;
    w.dp.st_op   = o;
    w.dp.cap_rb  = crb;
    w.dp.cap_g   = cg;
    return w;
  endfunction

  // One LCG advance takes four steps: full low product, two cross terms into
  // the upper half, then the state update with the increment.
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    case (pc)
      5'd0:    w = uword(SEQ_WAIT, PC_DRAW, MUL_NONE,  ST_HOLD, 1'b0, 1'b0);
      5'd1:    w = uword(SEQ_NEXT, PC_IDLE, MUL_NONE,  ST_CLR,  1'b0, 1'b0);
      5'd2:    w = uword(SEQ_NEXT, PC_IDLE, MUL_FULL,  ST_HOLD, 1'b0, 1'b0);
      5'd3:    w = uword(SEQ_NEXT, PC_IDLE, MUL_LO_HI, ST_HOLD, 1'b0, 1'b0);
      5'd4:    w = uword(SEQ_NEXT, PC_IDLE, MUL_HI_LO, ST_HOLD, 1'b0, 1'b0);
      5'd5:    w = uword(SEQ_NEXT, PC_IDLE, MUL_NONE,  ST_UPD,  1'b0, 1'b0);
      5'd6:    w = uword(SEQ_NEXT, PC_IDLE, MUL_NONE,  ST_SEED, 1'b0, 1'b0);
      5'd7:    w = uword(SEQ_NEXT, PC_IDLE, MUL_FULL,  ST_HOLD, 1'b0, 1'b0);
      5'd8:    w = uword(SEQ_NEXT, PC_IDLE, MUL_LO_HI, ST_HOLD, 1'b0, 1'b0);
      5'd9:    w = uword(SEQ_NEXT, PC_IDLE, MUL_HI_LO, ST_HOLD, 1'b0, 1'b0);
      5'd10:   w = uword(SEQ_NEXT, PC_IDLE, MUL_NONE,  ST_UPD,  1'b0, 1'b0);
      5'd11:   w = uword(SEQ_NEXT, PC_IDLE, MUL_FULL,  ST_HOLD, 1'b1, 1'b0);
      5'd12:   w = uword(SEQ_NEXT, PC_IDLE, MUL_LO_HI, ST_HOLD, 1'b0, 1'b0);
      5'd13:   w = uword(SEQ_NEXT, PC_IDLE, MUL_HI_LO, ST_HOLD, 1'b0, 1'b0);
      5'd14:   w = uword(SEQ_NEXT, PC_IDLE, MUL_NONE,  ST_UPD,  1'b0, 1'b0);
      5'd15:   w = uword(SEQ_NEXT, PC_IDLE, MUL_FULL,  ST_HOLD, 1'b0, 1'b1);
      5'd16:   w = uword(SEQ_NEXT, PC_IDLE, MUL_LO_HI, ST_HOLD, 1'b0, 1'b0);
      5'd17:   w = uword(SEQ_NEXT, PC_IDLE, MUL_HI_LO, ST_HOLD, 1'b0, 1'b0);
      5'd18:   w = uword(SEQ_NEXT, PC_IDLE, MUL_NONE,  ST_UPD,  1'b0, 1'b0);
      5'd19:   w = uword(SEQ_DONE, PC_IDLE, MUL_NONE,  ST_HOLD, 1'b0, 1'b0);
      default: w = uword(SEQ_NEXT, PC_IDLE, MUL_NONE,  ST_HOLD, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

  // XSH-RR output permutation of the pre-advance state, top 24 bits kept.
  function automatic logic [23:0] xsh_rr24(logic [63:0] s);
    logic [63:0] x;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] dbl;
    logic [31:0] r;
    x   = s ^ (s >> 18);
    xs  = x[58:27];
    rot = s[63:59];
    dbl = {xs, xs} >> rot;
    r   = dbl[31:0];
    return r[31:8];
  endfunction

endpackage

@@ src/pcg_sequencer.sv @@
// ----------------------------------------------------------------------------
// pcg_sequencer: microcode step counter
// Fetches one control word per step from the program table and chooses the
// next step: advance, wait for an input transfer, or wait to hand off a result.
// ----------------------------------------------------------------------------
module pcg_sequencer import pcg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     restart,
  input  logic     out_free,
  output logic     in_ready,
  output logic     load_out,
  output dp_ctrl_t ctrl
);

  pc_t    pc;
  pc_t    pc_next;
  ucode_t uw;

  assign uw = ucode_rom(pc);

  always_comb begin
    case (uw.seq_op)
      SEQ_WAIT: begin
        if (!in_valid) begin
          pc_next = pc;
        end else if (restart) begin
          pc_next = PC_RESEED;
        end else begin
          pc_next = uw.target;
        end
      end
      SEQ_DONE: pc_next = out_free ? uw.target : pc;
      default:  pc_next = pc + pc_t'(1);
    endcase
  end

  always_comb begin
    ctrl     = uw.dp;
    in_ready = (uw.seq_op == SEQ_WAIT);
    load_out = (uw.seq_op == SEQ_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ src/pcg_datapath.sv @@
// ----------------------------------------------------------------------------
// pcg_datapath: LCG state, shared 32x32 multiplier and draw capture
// The 64-bit state product is built from three 32x32 partial products in an
// accumulator, then the odd increment is added when the state is updated.
// ----------------------------------------------------------------------------
module pcg_datapath import pcg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_ctrl_t    ctrl,
  input  logic [31:0] seed,
  output logic [23:0] rb_draw,
  output logic [23:0] g_draw
);

  logic [63:0] state;
  logic [63:0] acc;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] inc;

  assign mul_a = (ctrl.mul_sel == MUL_HI_LO) ? state[63:32] : state[31:0];
  assign mul_b = (ctrl.mul_sel == MUL_LO_HI) ? MUL_HI : MUL_LO;
  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign inc   = {31'd0, seed, 1'b1};

  always_ff @(posedge clk) begin
    case (ctrl.mul_sel)
      MUL_FULL:  acc <= prod;
      MUL_LO_HI,
      MUL_HI_LO: acc[63:32] <= acc[63:32] + prod[31:0];
      default:   acc <= acc;
    endcase
    if (ctrl.cap_rb) begin
      rb_draw <= xsh_rr24(state);
    end
    if (ctrl.cap_g) begin
      g_draw <= xsh_rr24(state);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      case (ctrl.st_op)
        ST_CLR:  state <= '0;
        ST_SEED: state <= state + {32'd0, seed};
        ST_UPD:  state <= acc + inc;
        default: state <= state;
      endcase
    end
  end

endmodule

@@ src/pcg32_white_noise.sv @@
// ----------------------------------------------------------------------------
// pcg32_white_noise: PCG32 (XSH-RR) white-noise pixel source
// One input transfer requests one pixel; two draws give red/blue and green.
// ----------------------------------------------------------------------------
// Sequencing: no new pixel request is taken until the previous pixel is in
//   the output register; with restart, the state is first cleared, advanced,
//   offset by the seed and advanced again. Each LCG advance is four steps on
//   the single shared 32x32 multiplier, and a pixel needs two.
// Reset: rst clears the generator state and the seed to zero, empties the
//   output register and returns the sequencer to its idle step.
module pcg32_white_noise import pcg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Seed register write port.
  input  logic        seed_we,
  input  logic [31:0] seed_wdata,
  // Input channel: one transfer per pixel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  // Output channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] red_blue,
  output logic [23:0] green
);

  logic [31:0] seed;
  logic        out_free;
  logic        load_out;
  dp_ctrl_t    ctrl;
  logic [23:0] rb_draw;
  logic [23:0] g_draw;

  // The seed sets both the reseed offset and the odd stream increment
  // 2*seed+1, which is always taken from the current register value.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (seed_we) begin
      seed <= seed_wdata;
    end
  end

  // The output register may be refilled in the same cycle it is drained, so
  // the sequencer only stalls on its final step when a result is still unread.
  assign out_free = !out_valid || out_ready;

  pcg_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .restart  (restart),
    .out_free (out_free),
    .in_ready (in_ready),
    .load_out (load_out),
    .ctrl     (ctrl)
  );

  pcg_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .seed    (seed),
    .rb_draw (rb_draw),
    .g_draw  (g_draw)
  );

  // Output register: holds a finished pixel while the next one is computed.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      red_blue <= rb_draw;
      green    <= g_draw;
    end
  end

`ifndef NO_ASSERTIONS
  // After an input transfer the sequencer is busy and takes no other pixel.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // A result is only loaded when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("output register overwritten");

  // Loading a result always presents it on the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("loaded result not presented");

  // The two draws are captured in different steps.
  a_cap_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.cap_rb && ctrl.cap_g))
    else $error("both draws captured in one step");

  // No input is taken on the step that hands off a result.
  a_ready_not_load: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && load_out))
    else $error("input ready while handing off a result");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the PCG32 white-noise pixel source
// Drives pixel requests with and without restart across several seed values,
// predicts every pixel from a behavioral PCG32 XSH-RR generator kept inside
// the bench, and checks each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  // One pixel as the block returns it: two 0.24 fractions.
  typedef struct packed {
    logic [23:0] rb;
    logic [23:0] g;
  } pixel_t;

  // One row of the directed stimulus. When set_seed is high, the seed is
  // written (with the block idle) before the pixel is requested. When known
  // is high, the pixel below is the expected result, typed in by hand.
  typedef struct packed {
    bit          set_seed;
    logic [31:0] seed_val;
    bit          restart;
    bit          known;
    pixel_t      pixel;
  } pixel_row_t;

  localparam logic [63:0] LCG_MULT     = 64'h5851_F42D_4C95_7F2D;
  localparam int          RANDOM_ITEMS = 750;
  // The last stretch of the run goes without any idling on either side.
  localparam int          CALM_ITEMS   = 100;
  // Margin after the last pixel, longer than a pixel with restart takes.
  localparam int          SETTLE_CYCLES = 30;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        seed_we    = 1'b0;
  logic [31:0] seed_wdata = '0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        restart    = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [23:0] red_blue;
  logic [23:0] green;

  pcg32_white_noise i_dut (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_wdata (seed_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_blue   (red_blue),
    .green      (green)
  );

  // Bench copy of the generator: the 64-bit LCG state and the seed register.
  logic [63:0] lcg_state;
  logic [31:0] seed_copy;

  // Pixels predicted at input transfers, waiting for their output transfers.
  pixel_t pending_pixels[$];
  int     mismatch_count = 0;

  // Idling odds out of eight, shared by the sender and the receiver. It is
  // changed between phases so that some stretches idle a lot and some never.
  int     idle_odds = 2;
  int     stall_left = 0;

  // Directed part. Only the first row has a hand-written result: right after
  // reset state and seed are zero, so the draws permute 0 and 1, both giving 0.
  pixel_row_t directed_rows [14] = '{
    // No restart after reset: draws start from state zero.
    '{1'b0, 32'h0000_0000, 1'b0, 1'b1, '{24'h00_0000, 24'h00_0000}},
    '{1'b0, 32'h0000_0000, 1'b0, 1'b0, '{24'h0, 24'h0}},
    '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '{24'h0, 24'h0}},
    // New seed without restart: the increment changes, the state carries on.
    '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, '{24'h0, 24'h0}},
    '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '{24'h0, 24'h0}},
    '{1'b0, 32'h0000_0000, 1'b0, 1'b0, '{24'h0, 24'h0}},
    // Two restarts in a row must give the same pixel twice.
    '{1'b1, 32'h1234_5678, 1'b1, 1'b0, '{24'h0, 24'h0}},
    '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '{24'h0, 24'h0}},
    '{1'b1, 32'h0000_0001, 1'b0, 1'b0, '{24'h0, 24'h0}},
    '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '{24'h0, 24'h0}},
    '{1'b1, 32'h8000_0000, 1'b1, 1'b0, '{24'h0, 24'h0}},
    '{1'b0, 32'h0000_0000, 1'b0, 1'b0, '{24'h0, 24'h0}},
    // Back to seed zero, with restart, then one plain draw.
    '{1'b1, 32'h0000_0000, 1'b1, 1'b0, '{24'h0, 24'h0}},
    '{1'b0, 32'h0000_0000, 1'b0, 1'b0, '{24'h0, 24'h0}}
  };

  // 4 ns clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Generator model
  // ---------------------------------------------------------------------------

  // One LCG advance. The increment 2*seed+1 is read from the seed register at
  // every advance, so a new seed takes effect at once even without restart.
  function automatic logic [63:0] lcg_advance(logic [63:0] s, logic [31:0] sd);
    return s * LCG_MULT + {31'd0, sd, 1'b1};
  endfunction

  // XSH-RR permutation of the state before the advance.
  function automatic logic [31:0] xsh_rr(logic [63:0] s);
    logic [31:0] xs;
    int          rot;
    xs  = 32'((s ^ (s >> 18)) >> 27);
    rot = int'(s[63:59]);
    return (xs >> rot) | (xs << ((32 - rot) & 31));
  endfunction

  // One draw: permute the current state, then advance it.
  function automatic logic [31:0] noise_draw();
    logic [31:0] r;
    r         = xsh_rr(lcg_state);
    lcg_state = lcg_advance(lcg_state, seed_copy);
    return r;
  endfunction

  // Works out the pixel for one request and moves the bench generator on.
  // A restart replays the PCG seeding sequence: clear, advance, add the seed,
  // advance again. The first draw feeds red/blue, the second green.
  function automatic pixel_t next_noise_pixel(bit rs);
    pixel_t      px;
    logic [31:0] d;
    if (rs) begin
      lcg_state = lcg_advance(64'd0, seed_copy);
      lcg_state = lcg_state + {32'd0, seed_copy};
      lcg_state = lcg_advance(lcg_state, seed_copy);
    end
    d     = noise_draw();
    px.rb = d[31:8];
    d     = noise_draw();
    px.g  = d[31:8];
    return px;
  endfunction

  // Seeds for the random phases lean towards the extremes and single bits.
  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Requests one pixel. An optional idle burst comes first; valid then stays
  // high with the payload held until the transfer happens. The prediction is
  // made at the transfer, when the bench seed matches the block's seed.
  task automatic request_pixel(input bit rs, input bit known, input pixel_t typed);
    pixel_t px;
    int     gap;
    if (idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    px = next_noise_pixel(rs);
    pending_pixels.push_back(known ? typed : px);
  endtask

  // Writes the seed with the block idle: the sender holds off until every
  // predicted pixel has come out, so no advance can be under way.
  task automatic write_seed(input logic [31:0] v);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    seed_we    <= 1'b1;
    seed_wdata <= v;
    @(posedge clk);
    seed_we   <= 1'b0;
    seed_copy = v;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: ready drops in bursts of random length.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void log_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  // Every output transfer is compared against the oldest predicted pixel.
  // Signals are read at the edge itself, before any update of that edge.
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        log_mismatch($sformatf("unexpected pixel red_blue %06h green %06h",
                               red_blue, green));
      end else begin
        want = pending_pixels.pop_front();
        if (red_blue !== want.rb)
          log_mismatch($sformatf("red_blue mismatch: expected %06h, got %06h",
                                 want.rb, red_blue));
        if (green !== want.g)
          log_mismatch($sformatf("green mismatch: expected %06h, got %06h",
                                 want.g, green));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int left_in_phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Reset clears both the generator state and the seed.
    lcg_state = '0;
    seed_copy = '0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_seed) write_seed(directed_rows[i].seed_val);
      request_pixel(directed_rows[i].restart, directed_rows[i].known,
                    directed_rows[i].pixel);
    end

    // Random part, in phases. Each phase starts with a seed write on an idle
    // block, picks its own idling odds, and mostly keeps drawing from one
    // stream, with an occasional restart.
    left_in_phase = 0;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (left_in_phase == 0) begin
        write_seed(pick_seed());
        left_in_phase = $urandom_range(40, 120);
        idle_odds     = $urandom_range(0, 4);
      end
      if (k >= RANDOM_ITEMS - CALM_ITEMS) idle_odds = 0;
      left_in_phase--;
      request_pixel($urandom_range(0, 5) == 0, 1'b0, '0);
    end

    in_valid <= 1'b0;
    idle_odds = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // A few more cycles so that a stray extra pixel would still be caught.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
